// File: rtl/frb_pkg.sv
package frb_pkg;

    localparam logic [63:0] KEY_WHITEN = 64'h0f1e_2d3c_4b5a_6978;
    localparam int unsigned STEP_COUNT = 8;

    typedef logic [7:0] byte_t;

    function automatic logic [63:0] rotl64_3(input logic [63:0] v);
        return {v[60:0], v[63:61]};
    endfunction

    function automatic logic [15:0] rotl16(input logic [15:0] v, input logic [2:0] r);
        logic [31:0] t;
        t = {v, v} << r;
        return t[31:16];
    endfunction

    function automatic logic [15:0] rotr16(input logic [15:0] v, input logic [2:0] r);
        logic [31:0] t;
        t = {v, v} >> r;
        return t[15:0];
    endfunction

endpackage

// File: rtl/frb_round.sv
module frb_round (
    input  logic        mode,
    input  logic [63:0] work_key,
    input  logic [63:0] block_in,
    output logic [63:0] block_out
);

    frb_pkg::byte_t b  [frb_pkg::STEP_COUNT];
    frb_pkg::byte_t kb [frb_pkg::STEP_COUNT];

    always_comb
    begin
        logic [63:0]    wk;
        logic [15:0]    pair;
        logic [2:0]     p;
        logic [2:0]     q;
        logic [2:0]     s;
        frb_pkg::byte_t third;

        for (int i = 0; i < 8; i++)
        begin
            b[i] = block_in[63 - 8 * i -: 8];
        end

        wk = work_key;
        for (int k = 0; k < 8; k++)
        begin
            kb[k] = wk[7:0];
            wk    = frb_pkg::rotl64_3(wk);
        end

        for (int k = 0; k < 8; k++)
        begin
            if (!mode)
            begin
                p     = 3'(6 + k);
                q     = p + 3'd1;
                s     = p + 3'd2;
                third = b[s];
                pair  = frb_pkg::rotl16({b[p], b[q]}, third[2:0]);
                b[p]  = pair[15:8];
                b[q]  = pair[7:0];
                b[s]  = third ^ kb[k];
            end
            else
            begin
                p     = 3'(13 - k);
                q     = p + 3'd1;
                s     = p + 3'd2;
                third = b[s] ^ kb[7 - k];
                pair  = frb_pkg::rotr16({b[p], b[q]}, third[2:0]);
                b[p]  = pair[15:8];
                b[q]  = pair[7:0];
                b[s]  = third;
            end
        end

        for (int i = 0; i < 8; i++)
        begin
            block_out[63 - 8 * i -: 8] = b[i];
        end
    end

endmodule

// File: rtl/frame_rotate_block_cipher_64.sv
// Channel  | Valid      | Ready      | Payload
// ---------+------------+------------+---------------------
// input    | in_valid   | in_ready   | mode, data_block
// output   | out_valid  | out_ready  | result_block
// key      | cfg_write  | (none)     | cfg_data
//
// One round per pipeline stage: a block is accepted every cycle while the output is not stalled,
// and its result is offered from the last stage, which is the output register.
// Each stage holds eight chained frame steps, which sets the clock period.
// Reset clears the stage valid bits and sets the key to zero.
// A stall on the output freezes the whole pipeline; nothing is lost or repeated.
module frame_rotate_block_cipher_64 #(
    parameter int ROUND_COUNT = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [63:0] data_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_block
);

    logic [63:0] key_reg;
    logic [63:0] work_key;
    logic        advance;

    logic        valid_reg [ROUND_COUNT];
    logic        mode_reg  [ROUND_COUNT];
    logic [63:0] data_reg  [ROUND_COUNT];
    logic [63:0] round_out [ROUND_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_write)
        begin
            key_reg <= cfg_data;
        end
    end

    assign work_key = frb_pkg::rotl64_3(key_reg ^ frb_pkg::KEY_WHITEN);
    assign advance  = !valid_reg[ROUND_COUNT - 1] || out_ready;
    assign in_ready = advance;

    for (genvar i = 0; i < ROUND_COUNT; i++)
    begin : g_stage
        logic        stage_valid;
        logic        stage_mode;
        logic [63:0] stage_data;

        if (i == 0)
        begin : g_first
            assign stage_valid = in_valid;
            assign stage_mode  = mode;
            assign stage_data  = data_block;
        end
        else
        begin : g_next
            assign stage_valid = valid_reg[i - 1];
            assign stage_mode  = mode_reg[i - 1];
            assign stage_data  = data_reg[i - 1];
        end

        frb_round u_round (
            .mode      (stage_mode),
            .work_key  (work_key),
            .block_in  (stage_data),
            .block_out (round_out[i])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[i] <= stage_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                mode_reg[i] <= stage_mode;
                data_reg[i] <= round_out[i];
            end
        end
    end

    assign out_valid    = valid_reg[ROUND_COUNT - 1];
    assign result_block = data_reg[ROUND_COUNT - 1];

endmodule

// File: rtl/frb_checker.sv
module frb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result_block
);

    // A result that is held back must stay put until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_block))
        else $error("stalled result changed");

    // An empty output stage never holds back the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // A transfer on the output frees the whole pipeline for that cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> in_ready)
        else $error("input stalled during output transfer");

    // Reset empties the pipeline.
    assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind frame_rotate_block_cipher_64 frb_checker u_frb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_block (result_block)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int ROUNDS = 8;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_BLOCKS = 212;
    localparam int MAX_REPORTS = 10;

    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam logic [63:0] WHITEN = 64'h0f1e_2d3c_4b5a_6978;
    localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] LOW3_CLEAR = 64'hf8f8_f8f8_f8f8_f8f8;

    typedef struct packed {
        logic [63:0] key;
        logic        mode;
        logic [63:0] data;
        logic        undo;
        logic        typed;
        logic [63:0] want;
    } stim_row_t;

    localparam int PLAN_ROWS = 22;

    // An undo row sends the encryption of its data for decryption and expects the data back.
    localparam stim_row_t PLAN [PLAN_ROWS] = '{
        '{64'h0, MODE_ENC, 64'h0, 1'b0, 1'b0, 64'h0},
        '{64'h0, MODE_ENC, ONES, 1'b0, 1'b0, 64'h0},
        '{64'h0, MODE_DEC, 64'h0, 1'b0, 1'b0, 64'h0},
        '{64'h0, MODE_DEC, ONES, 1'b0, 1'b0, 64'h0},
        '{64'h0, MODE_ENC, 64'h0123_4567_89ab_cdef, 1'b0, 1'b0, 64'h0},
        '{64'h0, MODE_DEC, 64'h0123_4567_89ab_cdef, 1'b1, 1'b0, 64'h0},
        '{64'h0, MODE_ENC, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
        '{ONES, MODE_ENC, 64'h0, 1'b0, 1'b0, 64'h0},
        '{ONES, MODE_DEC, ONES, 1'b0, 1'b0, 64'h0},
        '{ONES, MODE_ENC, 64'hfedc_ba98_7654_3210, 1'b0, 1'b0, 64'h0},
        '{ONES, MODE_DEC, 64'h5a5a_c3c3_0ff0_a5a5, 1'b1, 1'b0, 64'h0},
        '{ONES, MODE_DEC, 64'h0000_0000_ffff_ffff, 1'b0, 1'b0, 64'h0},
        '{WHITEN, MODE_ENC, 64'h0, 1'b0, 1'b1, 64'h0},
        '{WHITEN, MODE_DEC, 64'h0, 1'b0, 1'b1, 64'h0},
        '{WHITEN, MODE_ENC, 64'hf8f0_e8d8_c8b8_a898, 1'b0, 1'b1, 64'hf8f0_e8d8_c8b8_a898},
        '{WHITEN, MODE_DEC, 64'h0008_1018_2028_3038, 1'b0, 1'b1, 64'h0008_1018_2028_3038},
        '{WHITEN, MODE_ENC, 64'h0102_0304_0506_0708, 1'b0, 1'b0, 64'h0},
        '{WHITEN, MODE_DEC, 64'h0102_0304_0506_0708, 1'b1, 1'b0, 64'h0},
        '{WHITEN, MODE_ENC, ONES, 1'b0, 1'b0, 64'h0},
        '{64'h8000_0000_0000_0000, MODE_ENC, 64'h1, 1'b0, 1'b0, 64'h0},
        '{64'h1, MODE_DEC, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
        '{64'h1, MODE_DEC, 64'h7766_5544_3322_1100, 1'b1, 1'b0, 64'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_write = 1'b0;
    logic [63:0] cfg_data = 64'h0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = MODE_ENC;
    logic [63:0] data_block = 64'h0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] result_block;

    logic [63:0] pending_blocks [$];
    logic [63:0] active_key = 64'h0;

    int burst_left = 0;
    int blocks_sent = 0;
    int decrypts_sent = 0;
    int results_seen = 0;
    int key_loads = 0;
    int mismatches = 0;
    int strays = 0;
    int idle_cycles = 0;

    int rx_mode = 0;
    int rx_left = 0;
    int rx_tick = 0;

    frame_rotate_block_cipher_64 #(
        .ROUND_COUNT(ROUNDS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .data_block(data_block),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .result_block(result_block)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] cipher_block(input logic m, input logic [63:0] blk,
                                                 input logic [63:0] key);
        logic [7:0]  b [8];
        logic [63:0] wk0;
        logic [63:0] wk;
        logic [63:0] res;
        logic [15:0] pair;
        logic [7:0]  third;
        logic [2:0]  amt;
        int          i;
        int          r;
        int          k;
        int          p;
        int          q;
        int          s;
        for (i = 0; i < 8; i++)
        begin
            b[i] = blk[63 - 8 * i -: 8];
        end
        wk0 = key ^ WHITEN;
        wk0 = {wk0[60:0], wk0[63:61]};
        for (r = 0; r < ROUNDS; r++)
        begin
            if (m == MODE_ENC)
            begin
                wk = wk0;
                for (k = 0; k < 8; k++)
                begin
                    p = (6 + k) % 8;
                    q = (p + 1) % 8;
                    s = (p + 2) % 8;
                    third = b[s];
                    amt = third[2:0];
                    pair = {b[p], b[q]};
                    pair = (pair << amt) | (pair >> (16 - amt));
                    b[p] = pair[15:8];
                    b[q] = pair[7:0];
                    b[s] = third ^ wk[7:0];
                    wk = {wk[60:0], wk[63:61]};
                end
            end
            else
            begin
                wk = {wk0[42:0], wk0[63:43]};
                for (k = 0; k < 8; k++)
                begin
                    p = (13 - k) % 8;
                    q = (p + 1) % 8;
                    s = (p + 2) % 8;
                    third = b[s] ^ wk[7:0];
                    amt = third[2:0];
                    pair = {b[p], b[q]};
                    pair = (pair >> amt) | (pair << (16 - amt));
                    b[p] = pair[15:8];
                    b[q] = pair[7:0];
                    b[s] = third;
                    wk = {wk[2:0], wk[63:3]};
                end
            end
        end
        for (i = 0; i < 8; i++)
        begin
            res[63 - 8 * i -: 8] = b[i];
        end
        return res;
    endfunction

    task automatic send_block(input logic m, input logic [63:0] d, input logic [63:0] want);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode <= m;
        data_block <= d;
        do
            @(posedge clk);
        while (!in_ready);
        pending_blocks.push_back(want);
        blocks_sent++;
        if (m == MODE_DEC)
        begin
            decrypts_sent++;
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic load_key(input logic [63:0] k);
        drain_results();
        cfg_write <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        cfg_write <= 1'b0;
        active_key = k;
        key_loads++;
    endtask

    always @(posedge clk)
    begin
        logic [63:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_blocks.size() == 0)
            begin
                strays++;
                if (mismatches + strays <= MAX_REPORTS)
                begin
                    $display("unexpected result %h", result_block);
                end
            end
            else
            begin
                want = pending_blocks.pop_front();
                results_seen++;
                if (result_block !== want)
                begin
                    mismatches++;
                    if (mismatches + strays <= MAX_REPORTS)
                    begin
                        $display("result mismatch: expected %h, got %h", want, result_block);
                    end
                end
            end
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= (rx_tick % 4) != 3;
            default: out_ready <= (rx_tick % 32) < 8;
        endcase
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   row;
        logic [63:0] k;
        logic [63:0] d;
        logic        m;
        int          idx;
        int          ph;
        int          n;
        int          sel;
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < PLAN_ROWS; idx++)
        begin
            row = PLAN[idx];
            if (row.key != active_key)
            begin
                load_key(row.key);
            end
            if (row.undo)
            begin
                send_block(MODE_DEC, cipher_block(MODE_ENC, row.data, active_key), row.data);
            end
            else if (row.typed)
            begin
                send_block(row.mode, row.data, row.want);
            end
            else
            begin
                send_block(row.mode, row.data, cipher_block(row.mode, row.data, active_key));
            end
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                1: k = 64'h0;
                2: k = ONES;
                3: k = WHITEN;
                default: k = {$urandom, $urandom};
            endcase
            load_key(k);
            for (n = 0; n < PHASE_BLOCKS; n++)
            begin
                if (ph == 4 && n == PHASE_BLOCKS / 2)
                begin
                    drain_results();
                end
                sel = $urandom_range(0, 9);
                m = 1'($urandom_range(0, 1));
                d = {$urandom, $urandom};
                case (sel)
                    6: d = d & LOW3_CLEAR;
                    7: d = (m == MODE_DEC) ? ~(64'h1 << $urandom_range(0, 63))
                                           : (64'h1 << $urandom_range(0, 63));
                    8:
                    begin
                        m = MODE_DEC;
                        d = cipher_block(MODE_ENC, d, active_key);
                    end
                    9: d = ($urandom_range(0, 1) == 1) ? ONES : 64'h0;
                    default: ;
                endcase
                send_block(m, d, cipher_block(m, d, active_key));
            end
        end

        drain_results();
        repeat (2 * ROUNDS + 8) @(posedge clk);

        $display("summary: %0d blocks sent (%0d decrypt) under %0d key loads, %0d results checked",
                 blocks_sent, decrypts_sent, key_loads, results_seen);
        $display("summary: %0d mismatches, %0d unexpected results", mismatches, strays);
        if (mismatches == 0 && strays == 0 && pending_blocks.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
